>>> design/gle_pkg.sv
// Package for the genotype likelihood engine: widths, codes, entry layout,
// state type and small helpers. Used by every module of the block but gle_ram.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package gle_pkg;

  // Store geometry
  localparam int VARIANTS     = 4096;
  localparam int ADDR_W       = $clog2(VARIANTS);
  localparam int MAX_STORAGES = 256;

  // Field widths
  localparam int ACT_W  = 3;
  localparam int VAR_W  = 12;
  localparam int PH_W   = 8;
  localparam int DRAW_W = 31;
  localparam int PROB_W = 32;
  localparam int CNT_W  = 9;
  localparam int HL_W   = 32;
  localparam int CALL_W = 2;
  localparam int STAT_W = 2;
  localparam int POST_W = 39;
  localparam int LIK_W  = 3 * PH_W;
  localparam int ENT_W  = LIK_W + 2 * POST_W + 2;

  // Arithmetic widths
  localparam int LIN_W  = 32;
  localparam int NUM_W  = 64;
  localparam int DEN_W  = 34;
  localparam int DCNT_W = $clog2(NUM_W);

  // Stream widths
  localparam int IN_DATA_W  = 208;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 152;
  localparam int OUT_USER_W = 2;

  // Fixed-point constants
  localparam logic [LIN_W-1:0]  ONE_Q31   = 32'h8000_0000;
  localparam logic [LIN_W-1:0]  TEN_RECIP = 32'hCCCC_CCCD;
  localparam logic [LIN_W-1:0]  TENTH_DB  = 32'd1705806895;
  localparam logic [POST_W-1:0] POST_MAX  = {POST_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX   = CNT_W'(MAX_STORAGES);

  // Actions
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 3'd0,
    ACT_INIT  = 3'd1,
    ACT_COND  = 3'd2,
    ACT_SAMPLE = 3'd3,
    ACT_ACCUM = 3'd4,
    ACT_NORM  = 3'd5,
    ACT_CALL  = 3'd6
  } action_t;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO_DEN = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT      = 2'd2;

  // Genotype codes
  localparam logic [CALL_W-1:0] GT_HOM_REF = 2'd0;
  localparam logic [CALL_W-1:0] GT_HET     = 2'd1;
  localparam logic [CALL_W-1:0] GT_HOM_ALT = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_LGO, S_LIN, S_MUL, S_PREP, S_DGO, S_DIV, S_POST, S_DONE
  } state_t;

  // Status of the phred-to-linear unit
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [LIN_W-1:0] value;
  } lin_res_t;

  // Status of the divider
  typedef struct packed {
    logic             busy;
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_res_t;

  // Limit a Q1.31 probability to 1.0
  function automatic logic [PROB_W-1:0] clamp_one(input logic [PROB_W-1:0] x);
    clamp_one = (x > ONE_Q31) ? ONE_Q31 : x;
  endfunction

endpackage
`default_nettype wire

>>> design/genotype_likelihood_engine_top.sv
// Top level of the genotype likelihood engine: sequencer, entry datapath and
// output register. Uses gle_pkg, gle_ram, gle_lin and gle_div.
//
// Usage:
//   Input stream (in_*): one transfer per action on one variant entry. tuser
//   carries the action and the haplotype select, tdata the variant index,
//   the three phred values, the random draw, four probabilities and count.
//   Output stream (out_*): exactly one result transfer per input transfer,
//   in order. tuser carries the status code.
//   Items are processed one at a time. Each one reads its entry from the
//   4096-entry store, works on it, writes it back and loads the output
//   register. Load, sample, call and unused codes use no serial unit.
//   Accumulate forms four rounded products, then runs both divides, and
//   normalize runs both divides; each skips them on a zero denominator.
//   init_hl and cond_hl run three likelihood conversions, then both
//   divides, which a zero conditional denominator skips.
//   in_tready is high whenever the sequencer is idle, also while a result
//   waits in the output register; a stalled receiver holds the next item in
//   its final step until the register frees.
//   Reset clears the sequencer and the output valid; the store has no reset
//   and each entry must be loaded before its first other use.
`timescale 1ns / 1ps
`default_nettype none
module genotype_likelihood_engine_top
  import gle_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [11:0] variant, [19:12] phred_hom_ref, [27:20] phred_het,
  // [35:28] phred_hom_alt, [66:36] random_draw, [98:67] prob_a_ref,
  // [130:99] prob_a_alt, [162:131] prob_b_ref, [194:163] prob_b_alt,
  // [203:195] storages_count, rest zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] action, [3] haplotype_select
  input  wire logic [IN_USER_W-1:0]  in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [31:0] hl_ref, [63:32] hl_alt, [65:64] genotype_call, [66] bit_hap0,
  // [67] bit_hap1, [106:68] post_hom_ref, [145:107] post_het, rest zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  // [1:0] status
  output logic [OUT_USER_W-1:0]      out_tuser
);

  state_t state_r, state_nxt;

  // Captured item
  logic [ACT_W-1:0]  act_r;
  logic [ADDR_W-1:0] var_r;
  logic [LIK_W-1:0]  ph_in_r;
  logic              sel_r;
  logic [DRAW_W-1:0] draw_r;
  logic [PROB_W-1:0] a_ref_r, a_alt_r, b_ref_r, b_alt_r;
  logic [CNT_W-1:0]  cnt_r;

  // Working copy of the entry
  logic [LIK_W-1:0]  lik_r;
  logic [POST_W-1:0] post0_r, post1_r;
  logic              h0_r, h1_r;

  // Intermediate values
  logic [LIN_W-1:0]  l_r [3];
  logic [1:0]        lk_r;
  logic [HL_W-1:0]   pr_r [4];
  logic [1:0]        mk_r;
  logic [NUM_W-1:0]  num0_r, num1_r;
  logic [DEN_W-1:0]  den_r;
  logic              dsel_r;
  logic [HL_W-1:0]   q0_r, q1_r;
  logic              skip_r;
  logic [HL_W-1:0]   hl_ref_r, hl_alt_r;
  logic [CALL_W-1:0] call_r;
  logic [STAT_W-1:0] status_r;

  // Output register
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;

  // Control strobes
  logic in_accept;
  logic lin_start;
  logic div_start;
  logic ram_we;
  logic out_load;

  // Store and units
  logic [ENT_W-1:0] ram_rdata;
  logic [ENT_W-1:0] ram_wdata;
  lin_res_t         lin_res;
  div_res_t         div_res;
  logic [PH_W-1:0]  lin_diff;
  logic [NUM_W-1:0] div_num;

  // Combinational helpers
  logic [PH_W-1:0]     p0, p1, p2, pmin, psel;
  logic [PROB_W-1:0]   mul_a, mul_b;
  logic [2*PROB_W-1:0] mul_p;
  logic [2*PROB_W-1:0] mul_rnd;
  logic [DEN_W-1:0]    l_sum;
  logic [DEN_W-1:0]    n_init0, n_init1;
  logic                cond_bit;
  logic [DEN_W-1:0]    ca, cb, c_den;
  logic [DEN_W-1:0]    g_p0, g_p1, g_t;
  logic [CNT_W-1:0]    c_lim;
  logic [POST_W:0]     acc0, acc1;
  logic signed [POST_W+1:0] g0, g1, g2;
  logic [CALL_W-1:0]   call_new;

  gle_ram #(
    .WIDTH (ENT_W),
    .DEPTH (VARIANTS),
    .ADDR_W(ADDR_W)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(var_r),
    .wdata(ram_wdata),
    .raddr(in_tdata[ADDR_W-1:0]),
    .rdata(ram_rdata)
  );

  gle_lin u_lin (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (lin_start),
    .phred_diff(lin_diff),
    .res       (lin_res)
  );

  gle_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_num),
    .divisor (den_r),
    .res     (div_res)
  );

  assign ram_wdata = {h1_r, h0_r, post1_r, post0_r, lik_r};

  // Phred difference from the minimum for the current likelihood
  assign p0   = lik_r[PH_W-1:0];
  assign p1   = lik_r[2*PH_W-1:PH_W];
  assign p2   = lik_r[3*PH_W-1:2*PH_W];
  assign pmin = (p0 <= p1 && p0 <= p2) ? p0 : ((p1 <= p2) ? p1 : p2);
  always_comb begin
    unique case (lk_r)
      2'd0:    psel = p0;
      2'd1:    psel = p1;
      default: psel = p2;
    endcase
  end
  assign lin_diff = psel - pmin;
  assign div_num  = dsel_r ? num1_r : num0_r;

  // Genotype product operands
  assign mul_a   = (mk_r[1] == 1'b0) ? clamp_one(a_ref_r) : clamp_one(a_alt_r);
  assign mul_b   = (mk_r[0] == 1'b0) ? clamp_one(b_ref_r) : clamp_one(b_alt_r);
  assign mul_p   = 64'(mul_a) * 64'(mul_b);
  assign mul_rnd = mul_p + 64'h4000_0000;

  // Ratio set-up terms
  assign l_sum    = DEN_W'(l_r[0]) + DEN_W'(l_r[1]) + DEN_W'(l_r[2]);
  assign n_init0  = (DEN_W'(l_r[0]) << 1) + DEN_W'(l_r[1]);
  assign n_init1  = (DEN_W'(l_r[2]) << 1) + DEN_W'(l_r[1]);
  assign cond_bit = sel_r ? h1_r : h0_r;
  assign ca       = cond_bit ? DEN_W'(l_r[1]) : DEN_W'(l_r[0]);
  assign cb       = cond_bit ? DEN_W'(l_r[2]) : DEN_W'(l_r[1]);
  assign c_den    = ca + cb;
  assign g_p0     = DEN_W'(pr_r[0]);
  assign g_p1     = DEN_W'(pr_r[1]) + DEN_W'(pr_r[2]);
  assign g_t      = g_p0 + g_p1 + DEN_W'(pr_r[3]);
  assign c_lim    = (cnt_r > CNT_MAX) ? CNT_MAX : cnt_r;

  // Posterior sums and call
  assign acc0 = {1'b0, post0_r} + (POST_W+1)'(q0_r);
  assign acc1 = {1'b0, post1_r} + (POST_W+1)'(q1_r);
  assign g0   = $signed({2'b00, post0_r});
  assign g1   = $signed({2'b00, post1_r});
  assign g2   = $signed((POST_W+2)'(ONE_Q31)) - g0 - g1;
  always_comb begin
    priority if (g2 >= g0 && g2 >= g1) begin
      call_new = GT_HOM_ALT;
    end else if (g1 >= g0 && g1 >= g2) begin
      call_new = GT_HET;
    end else begin
      call_new = GT_HOM_REF;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_accept) state_nxt = S_READ;
      S_READ: begin
        unique case (act_r)
          ACT_INIT, ACT_COND: state_nxt = S_LGO;
          ACT_ACCUM:          state_nxt = S_MUL;
          ACT_NORM:           state_nxt = S_PREP;
          default:            state_nxt = S_POST;
        endcase
      end
      S_LGO: state_nxt = S_LIN;
      S_LIN: begin
        if (lin_res.done) state_nxt = (lk_r == 2'd2) ? S_PREP : S_LGO;
      end
      S_MUL: if (mk_r == 2'd3) state_nxt = S_PREP;
      S_PREP: begin
        priority if (act_r == ACT_INIT) begin
          state_nxt = S_DGO;
        end else if (act_r == ACT_COND) begin
          state_nxt = (c_den == '0) ? S_POST : S_DGO;
        end else if (act_r == ACT_ACCUM) begin
          state_nxt = (g_t == '0) ? S_POST : S_DGO;
        end else begin
          state_nxt = (c_lim == '0) ? S_POST : S_DGO;
        end
      end
      S_DGO: state_nxt = S_DIV;
      S_DIV: begin
        if (div_res.done) state_nxt = dsel_r ? S_POST : S_DGO;
      end
      S_POST: state_nxt = S_DONE;
      S_DONE: if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_tready = (state_r == S_IDLE);
    lin_start = (state_r == S_LGO);
    div_start = (state_r == S_DGO);
    ram_we    = (state_r == S_DONE);
    out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);
  end
  assign in_accept = in_tvalid && in_tready;

  // Sequencer and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        // Capture the item
        if (in_accept) begin
          act_r    <= in_tuser[ACT_W-1:0];
          sel_r    <= in_tuser[ACT_W];
          var_r    <= in_tdata[ADDR_W-1:0];
          ph_in_r  <= in_tdata[35:12];
          draw_r   <= in_tdata[66:36];
          a_ref_r  <= in_tdata[98:67];
          a_alt_r  <= in_tdata[130:99];
          b_ref_r  <= in_tdata[162:131];
          b_alt_r  <= in_tdata[194:163];
          cnt_r    <= in_tdata[203:195];
          hl_ref_r <= '0;
          hl_alt_r <= '0;
          call_r   <= GT_HOM_REF;
          status_r <= STAT_OK;
          skip_r   <= 1'b0;
          lk_r     <= 2'd0;
          mk_r     <= 2'd0;
          dsel_r   <= 1'b0;
        end
      end
      S_READ: begin
        // Take the entry from the store
        lik_r   <= ram_rdata[LIK_W-1:0];
        post0_r <= ram_rdata[LIK_W+POST_W-1:LIK_W];
        post1_r <= ram_rdata[LIK_W+2*POST_W-1:LIK_W+POST_W];
        h0_r    <= ram_rdata[ENT_W-2];
        h1_r    <= ram_rdata[ENT_W-1];
      end
      S_LIN: begin
        // Store each linear likelihood as it finishes
        if (lin_res.done) begin
          l_r[lk_r] <= lin_res.value;
          lk_r      <= lk_r + 2'd1;
        end
      end
      S_MUL: begin
        // One rounded product per cycle
        pr_r[mk_r] <= HL_W'(mul_rnd >> 31);
        mk_r       <= mk_r + 2'd1;
      end
      S_PREP: begin
        // Set up numerators and denominator, or skip on a zero denominator
        priority if (act_r == ACT_INIT) begin
          den_r  <= l_sum;
          num0_r <= (NUM_W'(n_init0) << 30) + NUM_W'(l_sum >> 1);
          num1_r <= (NUM_W'(n_init1) << 30) + NUM_W'(l_sum >> 1);
        end else if (act_r == ACT_COND) begin
          den_r  <= c_den;
          num0_r <= (NUM_W'(ca) << 31) + NUM_W'(c_den >> 1);
          num1_r <= (NUM_W'(cb) << 31) + NUM_W'(c_den >> 1);
          if (c_den == '0) begin
            skip_r   <= 1'b1;
            status_r <= STAT_ZERO_DEN;
          end
        end else if (act_r == ACT_ACCUM) begin
          den_r  <= g_t;
          num0_r <= (NUM_W'(g_p0) << 31) + NUM_W'(g_t >> 1);
          num1_r <= (NUM_W'(g_p1) << 31) + NUM_W'(g_t >> 1);
          if (g_t == '0) begin
            skip_r   <= 1'b1;
            status_r <= STAT_ZERO_DEN;
          end
        end else begin
          den_r  <= DEN_W'(c_lim);
          num0_r <= NUM_W'(post0_r) + NUM_W'(c_lim >> 1);
          num1_r <= NUM_W'(post1_r) + NUM_W'(c_lim >> 1);
          if (c_lim == '0) begin
            skip_r   <= 1'b1;
            status_r <= STAT_ZERO_DEN;
          end
        end
      end
      S_DIV: begin
        // Hold both quotients, and for normalize the new posteriors
        if (div_res.done) begin
          if (dsel_r) begin
            q1_r <= HL_W'(div_res.quotient);
          end else begin
            q0_r <= HL_W'(div_res.quotient);
            if (act_r == ACT_NORM) begin
              post0_r <= POST_W'(div_res.quotient);
            end
          end
          if (dsel_r && act_r == ACT_NORM) begin
            post1_r <= POST_W'(div_res.quotient);
          end
          dsel_r <= 1'b1;
        end
      end
      S_POST: begin
        // Apply the action to the entry
        unique case (act_r)
          ACT_LOAD: begin
            lik_r   <= ph_in_r;
            post0_r <= '0;
            post1_r <= '0;
            h0_r    <= 1'b0;
            h1_r    <= 1'b0;
          end
          ACT_INIT, ACT_COND: begin
            if (!skip_r) begin
              hl_ref_r <= q0_r;
              hl_alt_r <= q1_r;
            end
          end
          ACT_SAMPLE: begin
            if (sel_r) begin
              h1_r <= !(PROB_W'(draw_r) < a_ref_r);
            end else begin
              h0_r <= !(PROB_W'(draw_r) < a_ref_r);
            end
          end
          ACT_ACCUM: begin
            if (!skip_r) begin
              post0_r <= (acc0 > (POST_W+1)'(POST_MAX)) ? POST_MAX : acc0[POST_W-1:0];
              post1_r <= (acc1 > (POST_W+1)'(POST_MAX)) ? POST_MAX : acc1[POST_W-1:0];
              if (acc0 > (POST_W+1)'(POST_MAX) || acc1 > (POST_W+1)'(POST_MAX)) begin
                status_r <= STAT_SAT;
              end
            end
          end
          ACT_CALL: begin
            call_r <= call_new;
            h0_r   <= (call_new == GT_HOM_ALT);
            h1_r   <= (call_new != GT_HOM_REF);
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= {6'b0, post1_r, post0_r, h1_r, h0_r, call_r, hl_alt_r, hl_ref_r};
      out_user_r <= status_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Checks
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_res.busy)
    else $error("divider started while busy");

  a_lin_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    lin_start |-> !lin_res.busy)
    else $error("likelihood unit started while busy");

  a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == S_READ)
    else $error("accepted item did not read its entry");

  a_codes_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser != 2'd3 && out_tdata[65:64] != 2'd3))
    else $error("result carries an undefined code");

endmodule
`default_nettype wire

>>> design/gle_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module gle_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/gle_lin.sv
// Phred difference to linear Q1.31 likelihood: one divide-by-ten or one
// tenth-decibel multiply per cycle on a shared multiplier. Uses gle_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gle_lin
  import gle_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [PH_W-1:0] phred_diff,
  output lin_res_t             res
);

  logic [LIN_W-1:0]   v_r;
  logic [4:0]         ten_r;
  logic [3:0]         unit_r;
  logic               busy_r;
  logic               done_r;
  logic [15:0]        tens_prod;
  logic [4:0]         tens;
  logic [7:0]         tens_x10;
  logic [LIN_W-1:0]   mul_a;
  logic [LIN_W-1:0]   mul_b;
  logic [2*LIN_W-1:0] prod;
  logic [2*LIN_W-1:0] prod_rnd;
  logic [LIN_W-1:0]   v_nxt;

  // Split the difference into whole tens and remaining units
  assign tens_prod = 16'(phred_diff) * 16'd205;
  assign tens      = tens_prod[15:11];
  assign tens_x10  = 8'(tens) * 8'd10;

  // Shared multiplier: reciprocal of ten or one tenth decibel
  assign mul_a    = (ten_r != '0) ? v_r + 32'd5 : v_r;
  assign mul_b    = (ten_r != '0) ? TEN_RECIP : TENTH_DB;
  assign prod     = 64'(mul_a) * 64'(mul_b);
  assign prod_rnd = prod + 64'h4000_0000;
  assign v_nxt    = (ten_r != '0) ? LIN_W'(prod >> 35) : LIN_W'(prod_rnd >> 31);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && ten_r == '0 && unit_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Iterate the value
  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= ONE_Q31;
      ten_r  <= tens;
      unit_r <= 4'(phred_diff - tens_x10);
    end else if (busy_r) begin
      if (ten_r != '0) begin
        v_r   <= v_nxt;
        ten_r <= ten_r - 5'd1;
      end else if (unit_r != '0) begin
        v_r    <= v_nxt;
        unit_r <= unit_r - 4'd1;
      end
    end
  end

  assign res.busy  = busy_r;
  assign res.done  = done_r;
  assign res.value = v_r;

endmodule
`default_nettype wire

>>> design/gle_div.sv
// Restoring divider, one quotient bit per cycle, for all ratios and the
// posterior normalisation. Uses gle_pkg.
`timescale 1ns / 1ps
`default_nettype none
module gle_div
  import gle_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] dividend,
  input  wire logic [DEN_W-1:0] divisor,
  output div_res_t              res
);

  logic [NUM_W-1:0]  quo_r;
  logic [DEN_W:0]    rem_r;
  logic [DEN_W-1:0]  div_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DEN_W:0]    rem_sh;
  logic              ge;

  // One restoring step
  assign rem_sh = {rem_r[DEN_W-1:0], quo_r[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, div_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == DCNT_W'(NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Shift dividend in, quotient bits out
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
      cnt_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? rem_sh - {1'b0, div_r} : rem_sh;
      cnt_r <= cnt_r + DCNT_W'(1);
    end
  end

  assign res.busy     = busy_r;
  assign res.done     = done_r;
  assign res.quotient = quo_r;

endmodule
`default_nettype wire

>>> bench/gle_checker.sv
// Checker for the genotype likelihood engine: watches both streams, keeps its
// own copy of the per-variant store, predicts each result and compares.
// Depends on gle_pkg for widths, action and status codes.
`timescale 1ns / 1ps
module gle_checker
  import gle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic [OUT_USER_W-1:0] out_tuser,
  output int                    failures,
  output int                    pending
);

  typedef struct packed {
    logic [HL_W-1:0]   hl_ref;
    logic [HL_W-1:0]   hl_alt;
    logic [CALL_W-1:0] call;
    logic              hap0;
    logic              hap1;
    logic [POST_W-1:0] post_ref;
    logic [POST_W-1:0] post_het;
    logic [STAT_W-1:0] status;
  } gl_result_t;

  // Model of the entry store
  logic [LIK_W-1:0]  lik_mem      [VARIANTS];
  logic [POST_W-1:0] post_ref_mem [VARIANTS];
  logic [POST_W-1:0] post_het_mem [VARIANTS];
  logic              hap0_mem     [VARIANTS];
  logic              hap1_mem     [VARIANTS];

  gl_result_t expected_q[$];
  int         result_no;

  localparam longint unsigned Q31_ONE = 64'h8000_0000;
  localparam longint unsigned Q31_HALF = 64'h4000_0000;

  // Phred difference to linear Q1.31: divide by ten per decade, then tenth steps
  function automatic longint unsigned phred_to_linear(int unsigned d);
    longint unsigned v;
    v = Q31_ONE;
    for (int i = 0; i < d / 10; i++) v = (v + 5) / 10;
    for (int i = 0; i < d % 10; i++) v = (v * 64'(TENTH_DB) + Q31_HALF) >> 31;
    return v;
  endfunction

  function automatic longint unsigned q31_ratio(longint unsigned num, longint unsigned den);
    return ((num << 31) + den / 2) / den;
  endfunction

  function automatic longint unsigned q31_mul(longint unsigned a, longint unsigned b);
    return (a * b + Q31_HALF) >> 31;
  endfunction

  function automatic longint unsigned prob_limit(logic [PROB_W-1:0] p);
    return (64'(p) > Q31_ONE) ? Q31_ONE : 64'(p);
  endfunction

  // Work out one result and advance the model store
  function automatic gl_result_t predict_entry(logic [IN_DATA_W-1:0] d,
                                               logic [IN_USER_W-1:0] u);
    gl_result_t r;
    logic [ACT_W-1:0] act;
    int unsigned idx, ph[3], mn, cnt;
    longint unsigned l[3], sum, a, b, ar, aa, br, ba, p0, p1, p2, t, s0, s1;
    longint g0, g1, g2;
    logic cbit;
    act = u[2:0];
    idx = d[11:0];
    r = '0;
    for (int k = 0; k < 3; k++) ph[k] = lik_mem[idx][8*k +: 8];
    mn = ph[0];
    if (ph[1] < mn) mn = ph[1];
    if (ph[2] < mn) mn = ph[2];
    for (int k = 0; k < 3; k++) l[k] = phred_to_linear(ph[k] - mn);
    case (act)
      ACT_LOAD: begin
        lik_mem[idx] = d[35:12];
        post_ref_mem[idx] = '0;
        post_het_mem[idx] = '0;
        hap0_mem[idx] = 1'b0;
        hap1_mem[idx] = 1'b0;
      end
      ACT_INIT: begin
        sum = l[0] + l[1] + l[2];
        r.hl_ref = HL_W'((((2 * l[0] + l[1]) << 30) + sum / 2) / sum);
        r.hl_alt = HL_W'((((2 * l[2] + l[1]) << 30) + sum / 2) / sum);
      end
      ACT_COND: begin
        cbit = u[3] ? hap1_mem[idx] : hap0_mem[idx];
        a = cbit ? l[1] : l[0];
        b = cbit ? l[2] : l[1];
        if (a + b == 0) r.status = STAT_ZERO_DEN;
        else begin
          r.hl_ref = HL_W'(q31_ratio(a, a + b));
          r.hl_alt = HL_W'(q31_ratio(b, a + b));
        end
      end
      ACT_SAMPLE: begin
        cbit = (64'(d[66:36]) < 64'(d[98:67])) ? 1'b0 : 1'b1;
        if (u[3]) hap1_mem[idx] = cbit;
        else hap0_mem[idx] = cbit;
      end
      ACT_ACCUM: begin
        ar = prob_limit(d[98:67]);
        aa = prob_limit(d[130:99]);
        br = prob_limit(d[162:131]);
        ba = prob_limit(d[194:163]);
        p0 = q31_mul(ar, br);
        p1 = q31_mul(ar, ba) + q31_mul(aa, br);
        p2 = q31_mul(aa, ba);
        t = p0 + p1 + p2;
        if (t == 0) r.status = STAT_ZERO_DEN;
        else begin
          s0 = 64'(post_ref_mem[idx]) + q31_ratio(p0, t);
          s1 = 64'(post_het_mem[idx]) + q31_ratio(p1, t);
          if (s0 > 64'(POST_MAX)) begin
            s0 = 64'(POST_MAX);
            r.status = STAT_SAT;
          end
          if (s1 > 64'(POST_MAX)) begin
            s1 = 64'(POST_MAX);
            r.status = STAT_SAT;
          end
          post_ref_mem[idx] = POST_W'(s0);
          post_het_mem[idx] = POST_W'(s1);
        end
      end
      ACT_NORM: begin
        cnt = d[203:195];
        if (cnt > MAX_STORAGES) cnt = MAX_STORAGES;
        if (cnt == 0) r.status = STAT_ZERO_DEN;
        else begin
          post_ref_mem[idx] = POST_W'((64'(post_ref_mem[idx]) + cnt / 2) / cnt);
          post_het_mem[idx] = POST_W'((64'(post_het_mem[idx]) + cnt / 2) / cnt);
        end
      end
      ACT_CALL: begin
        g0 = longint'(post_ref_mem[idx]);
        g1 = longint'(post_het_mem[idx]);
        g2 = longint'(Q31_ONE) - g0 - g1;
        if (g0 >= g1 && g0 >= g2) r.call = GT_HOM_REF;
        if (g1 >= g0 && g1 >= g2) r.call = GT_HET;
        if (g2 >= g0 && g2 >= g1) r.call = GT_HOM_ALT;
        hap0_mem[idx] = (r.call == GT_HOM_ALT);
        hap1_mem[idx] = (r.call != GT_HOM_REF);
      end
      default: ;
    endcase
    r.hap0 = hap0_mem[idx];
    r.hap1 = hap1_mem[idx];
    r.post_ref = post_ref_mem[idx];
    r.post_het = post_het_mem[idx];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("result %0d: %s is %0h, expected %0h", result_no, field, got, want);
    failures++;
  endtask

  initial begin
    failures = 0;
    pending = 0;
    result_no = 0;
  end

  // Compare each result transfer first, then take in the input transfer
  always @(posedge clk) begin
    gl_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("result %0d: no result was due", result_no);
          failures++;
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[31:0] !== want.hl_ref) report_mismatch("hl_ref", out_tdata[31:0], want.hl_ref);
          if (out_tdata[63:32] !== want.hl_alt) report_mismatch("hl_alt", out_tdata[63:32], want.hl_alt);
          if (out_tdata[65:64] !== want.call) report_mismatch("genotype_call", out_tdata[65:64], want.call);
          if (out_tdata[66] !== want.hap0) report_mismatch("bit_hap0", out_tdata[66], want.hap0);
          if (out_tdata[67] !== want.hap1) report_mismatch("bit_hap1", out_tdata[67], want.hap1);
          if (out_tdata[106:68] !== want.post_ref)
            report_mismatch("post_hom_ref", out_tdata[106:68], want.post_ref);
          if (out_tdata[145:107] !== want.post_het)
            report_mismatch("post_het", out_tdata[145:107], want.post_het);
          if (out_tuser[1:0] !== want.status) report_mismatch("status", out_tuser[1:0], want.status);
        end
        result_no++;
      end
      if (in_tvalid && in_tready) expected_q.push_back(predict_entry(in_tdata, in_tuser));
      pending = expected_q.size();
    end
  end

endmodule

>>> bench/genotype_likelihood_engine_top_tb.sv
// Testbench top for the genotype likelihood engine: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on gle_pkg, the engine top
// and gle_checker, which does all prediction and comparison.
`timescale 1ns / 1ps
module genotype_likelihood_engine_top_tb;
  import gle_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
  localparam int IDLE_LIMIT = 6000;
  localparam int RANDOM_ITEMS = 190;
  localparam logic [PROB_W-1:0] P_ONE = 32'h8000_0000;

  typedef struct {
    logic [ACT_W-1:0]  act;
    logic [VAR_W-1:0]  variant;
    logic [PH_W-1:0]   ph0, ph1, ph2;
    logic              sel;
    logic [DRAW_W-1:0] draw;
    logic [PROB_W-1:0] par, paa, pbr, pba;
    logic [CNT_W-1:0]  cnt;
  } gl_item_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  int                    failures;
  int                    pending;

  int         sent_count;
  int         idle_cycles;
  bit         burst_mode;
  bit         loaded[VARIANTS];
  int         loaded_q[$];

  genotype_likelihood_engine_top dut (.*);

  gle_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Draw a probability, leaning on the edges and values above one
  function automatic logic [PROB_W-1:0] draw_prob();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return P_ONE;
      2: return $urandom();
      default: return $urandom_range(0, 32'h8000_0000);
    endcase
  endfunction

  function automatic gl_item_t make_item(logic [ACT_W-1:0] act, logic [VAR_W-1:0] v);
    gl_item_t it;
    it.act = act;
    it.variant = v;
    it.ph0 = PH_W'($urandom());
    it.ph1 = PH_W'($urandom());
    it.ph2 = PH_W'($urandom());
    it.sel = 1'($urandom());
    it.draw = DRAW_W'($urandom());
    it.par = draw_prob();
    it.paa = draw_prob();
    it.pbr = draw_prob();
    it.pba = draw_prob();
    it.cnt = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom()) : CNT_W'($urandom_range(1, 8));
    return it;
  endfunction

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(gl_item_t it);
    int gap;
    gap = 0;
    if (!burst_mode && $urandom_range(0, 9) >= 6)
      gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    repeat (gap) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    if (it.act == ACT_LOAD && !loaded[it.variant]) begin
      loaded[it.variant] = 1'b1;
      loaded_q.push_back(it.variant);
    end
    in_tvalid = 1'b1;
    in_tuser = {it.sel, it.act};
    in_tdata = {4'b0, it.cnt, it.pba, it.pbr, it.paa, it.par, it.draw,
                it.ph2, it.ph1, it.ph0, it.variant};
    do @(posedge clk); while (!in_tready);
    sent_count++;
    if (sent_count % 60 == 0) burst_mode = ~burst_mode;
    @(negedge clk);
  endtask

  task automatic send_load(logic [VAR_W-1:0] v, logic [PH_W-1:0] a, b, c);
    gl_item_t it;
    it = make_item(ACT_LOAD, v);
    it.ph0 = a;
    it.ph1 = b;
    it.ph2 = c;
    send_item(it);
  endtask

  task automatic send_prob(logic [ACT_W-1:0] act, logic [VAR_W-1:0] v, logic s,
                           logic [PROB_W-1:0] ar, aa, br, ba);
    gl_item_t it;
    it = make_item(act, v);
    it.sel = s;
    it.par = ar;
    it.paa = aa;
    it.pbr = br;
    it.pba = ba;
    send_item(it);
  endtask

  // Stimulus
  initial begin
    gl_item_t it;
    logic [VAR_W-1:0] v;
    int n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    sent_count = 0;
    burst_mode = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extreme likelihoods, zero denominators, draw edges, counts
    send_load(12'd0, 8'd0, 8'd0, 8'd0);
    send_load(12'd4095, 8'd255, 8'd255, 8'd0);
    send_load(12'd1, 8'd0, 8'd255, 8'd255);
    send_load(12'd2, 8'd37, 8'd0, 8'd129);
    send_item(make_item(ACT_INIT, 12'd0));
    send_item(make_item(ACT_INIT, 12'd4095));
    send_item(make_item(ACT_INIT, 12'd2));
    send_prob(ACT_COND, 12'd4095, 1'b0, '0, '0, '0, '0);
    send_prob(ACT_COND, 12'd2, 1'b1, '0, '0, '0, '0);
    it = make_item(ACT_SAMPLE, 12'd1);
    it.sel = 1'b1;
    it.draw = '1;
    it.par = 32'hFFFF_FFFF;
    send_item(it);
    it.draw = '1;
    it.par = 32'h7FFF_FFFF;
    send_item(it);
    send_prob(ACT_COND, 12'd1, 1'b1, '0, '0, '0, '0);
    it = make_item(ACT_SAMPLE, 12'd0);
    it.sel = 1'b0;
    it.draw = '0;
    it.par = '0;
    send_item(it);
    send_prob(ACT_COND, 12'd0, 1'b0, '0, '0, '0, '0);
    send_prob(ACT_ACCUM, 12'd2, 1'b0, '0, '0, '0, '0);
    send_prob(ACT_ACCUM, 12'd2, 1'b0, 32'hFFFF_FFFF, 32'h4000_0000, P_ONE, 32'h3000_0000);
    send_prob(ACT_ACCUM, 12'd2, 1'b0, 32'h2000_0000, P_ONE, 32'h1234_5678, 32'hFFFF_FFFF);
    it = make_item(ACT_NORM, 12'd2);
    it.cnt = '0;
    send_item(it);
    it.cnt = 9'd511;
    send_item(it);
    it.cnt = 9'd2;
    send_item(it);
    send_item(make_item(ACT_CALL, 12'd2));
    send_item(make_item(ACT_CALL, 12'd0));
    send_item(make_item(ACT_UNUSED, 12'd4095));

    // Saturate one entry's posterior by repeated certain reference accumulations
    send_load(12'd3, 8'd10, 8'd20, 8'd30);
    for (int i = 0; i < 260; i++) send_prob(ACT_ACCUM, 12'd3, 1'b0, P_ONE, '0, P_ONE, '0);
    send_item(make_item(ACT_CALL, 12'd3));

    // Random sequences on loaded entries: load, then a few actions
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) v = VAR_W'($urandom_range(0, VARIANTS - 1));
      else v = VAR_W'(loaded_q[$urandom_range(0, loaded_q.size() - 1)]);
      if (!loaded[v] || $urandom_range(0, 3) == 0) begin
        send_item(make_item(ACT_LOAD, v));
        n++;
      end
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 11))
          0: it = make_item(ACT_INIT, v);
          1, 2: it = make_item(ACT_COND, v);
          3, 4: it = make_item(ACT_SAMPLE, v);
          5, 6, 7: it = make_item(ACT_ACCUM, v);
          8: it = make_item(ACT_NORM, v);
          9, 10: it = make_item(ACT_CALL, v);
          default: it = make_item(($urandom_range(0, 1) != 0) ? ACT_UNUSED : ACT_LOAD, v);
        endcase
        send_item(it);
        n++;
      end
    end
    in_tvalid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (failures == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Receiver: random stalls, and one long hold-off to back up the input
  initial begin
    bit held;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sent_count >= 30) begin
        held = 1'b1;
        out_tready = 1'b0;
        repeat (800) @(negedge clk);
      end else if (burst_mode) begin
        out_tready = 1'b1;
      end else if ($urandom_range(0, 99) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(20, 80)) @(negedge clk);
      end else begin
        out_tready = ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Watchdog: end the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
